// File: rtl/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// Radix-2 FFT package
// Shared types, the controller-to-datapath command struct and the sine table.
// ----------------------------------------------------------------------------
`default_nettype none

package r2fft_pkg;

    // Configuration register indexes.
    localparam logic [0:0] REG_SIZE_LOG2    = 1'b0;
    localparam logic [0:0] REG_INVERSE_MODE = 1'b1;

    // Datapath operation codes issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SWAP_RD,
        OP_SWAP_WR,
        OP_BF_RD,
        OP_BF_WR,
        OP_SCALE,
        OP_EMIT
    } op_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        op_t        op;
        logic [5:0] addr_a;
        logic [5:0] addr_b;
        logic [4:0] tw_step;
        logic [2:0] shift;
        logic       inverse;
        logic       last;
    } dp_cmd_t;

    // sin(pi*k/32) * 2^30 for k = 0..16.
    function automatic logic [30:0] quarter_sine(input logic [4:0] k);
        logic [30:0] v;
        begin
            case (k)
                5'd0:    v = 31'd0;
                5'd1:    v = 31'd105245103;
                5'd2:    v = 31'd209476638;
                5'd3:    v = 31'd311690799;
                5'd4:    v = 31'd410903207;
                5'd5:    v = 31'd506158392;
                5'd6:    v = 31'd596538995;
                5'd7:    v = 31'd681174602;
                5'd8:    v = 31'd759250125;
                5'd9:    v = 31'd830013654;
                5'd10:   v = 31'd892783698;
                5'd11:   v = 31'd946955747;
                5'd12:   v = 31'd992008094;
                5'd13:   v = 31'd1027506862;
                5'd14:   v = 31'd1053110176;
                5'd15:   v = 31'd1068571464;
                default: v = 31'd1073741824;
            endcase
            return v;
        end
    endfunction

    // Saturate a 34-bit value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        begin
            if (v > 34'sh0_7FFF_FFFF)
                return 32'sh7FFF_FFFF;
            else if (v < -34'sh0_8000_0000)
                return 32'sh8000_0000;
            else
                return v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/r2fft_datapath.sv
// ----------------------------------------------------------------------------
// Radix-2 FFT datapath
// Work memory, twiddle lookup, one butterfly unit and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module r2fft_datapath #(
    parameter int MAX_POINTS   = 64,
    parameter int TWIDDLE_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire r2fft_pkg::dp_cmd_t    cmd,
    input  wire logic signed [15:0]    sample_real,
    input  wire logic signed [15:0]    sample_imag,
    output logic                       bin_valid,
    output logic signed [31:0]         bin_real,
    output logic signed [31:0]         bin_imag,
    output logic [5:0]                 bin_index,
    output logic                       bin_last
);

    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int FRAC = TWIDDLE_BITS - 1;
    localparam int SH   = 30 - FRAC;
    localparam int TW   = TWIDDLE_BITS + 1;

    // Work memory with two read ports and two write ports, one array for the real
    // parts and one for the imaginary parts: both operands of one butterfly are read and written together.
    logic signed [31:0] mem_re [MAX_POINTS];
    logic signed [31:0] mem_im [MAX_POINTS];

    logic signed [31:0] ar_reg, ai_reg, xr_reg, xi_reg;
    logic [AW-1:0]      pa_reg, pb_reg;
    logic signed [TW-1:0] c_reg, s_reg;
    logic signed [31:0] dr_reg, di_reg;
    logic               bf_mul_reg;
    logic               emit_reg;
    logic [5:0]         emit_idx_reg;
    logic               emit_last_reg;
    logic [2:0]         shift_reg;
    logic               scale_reg;

    logic [AW-1:0] addr_a, addr_b;
    assign addr_a = cmd.addr_a[AW-1:0];
    assign addr_b = cmd.addr_b[AW-1:0];

    // Twiddle value for one table step (0..16), rounded, top saturated.
    function automatic logic signed [TW-1:0] tw_of(input logic [4:0] k);
        logic [31:0] v;
        logic [31:0] top;
        begin
            v   = ({1'b0, r2fft_pkg::quarter_sine(k)} + (32'd1 << (SH - 1))) >> SH;
            top = (32'd1 << FRAC) - 32'd1;
            if (v > top)
                v = top;
            return TW'(signed'({1'b0, v[TW-2:0]}));
        end
    endfunction

    // Cosine and sine for the angle h (0..31 steps of pi/32).
    logic [4:0] h;
    logic signed [TW-1:0] cos_h, sin_h;
    assign h = cmd.tw_step;
    always_comb
    begin
        if (h <= 5'd16)
        begin
            sin_h = tw_of(h);
            cos_h = tw_of(5'd16 - h);
        end
        else
        begin
            sin_h = tw_of(5'd0 - h);
            cos_h = -tw_of(h - 5'd16);
        end
    end

    // Twiddle products, one complex multiply per butterfly.
    logic signed [TW+32:0] pr, pi;
    logic signed [TW+32:0] rnd;
    logic signed [TW+32:0] dr_full, di_full;
    logic signed [33:0]    dr_sat_in, di_sat_in;
    always_comb
    begin
        rnd = (TW+33)'(1) <<< (FRAC - 1);
        pr  = s_reg * xi_reg + c_reg * xr_reg + rnd;
        pi  = c_reg * xi_reg - s_reg * xr_reg + rnd;
        dr_full = pr >>> FRAC;
        di_full = pi >>> FRAC;
        if (dr_full > (TW+33)'(34'sh0_7FFF_FFFF))
            dr_sat_in = 34'sh0_7FFF_FFFF;
        else if (dr_full < -(TW+33)'(34'sh0_8000_0000))
            dr_sat_in = -34'sh0_8000_0000;
        else
            dr_sat_in = dr_full[33:0];
        if (di_full > (TW+33)'(34'sh0_7FFF_FFFF))
            di_sat_in = 34'sh0_7FFF_FFFF;
        else if (di_full < -(TW+33)'(34'sh0_8000_0000))
            di_sat_in = -34'sh0_8000_0000;
        else
            di_sat_in = di_full[33:0];
    end

    // Memory ports: reads registered, writes from load, swap, butterfly and scale.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            r2fft_pkg::OP_LOAD:
            begin
                mem_re[addr_a] <= 32'(sample_real);
                mem_im[addr_a] <= 32'(sample_imag);
            end
            r2fft_pkg::OP_SWAP_WR:
            begin
                mem_re[addr_a] <= xr_reg;
                mem_im[addr_a] <= xi_reg;
                mem_re[addr_b] <= ar_reg;
                mem_im[addr_b] <= ai_reg;
            end
            r2fft_pkg::OP_BF_WR:
            begin
                mem_re[pa_reg] <= r2fft_pkg::sat32(34'(ar_reg) + 34'(dr_reg));
                mem_im[pa_reg] <= r2fft_pkg::sat32(34'(ai_reg) + 34'(di_reg));
                mem_re[pb_reg] <= r2fft_pkg::sat32(34'(ar_reg) - 34'(dr_reg));
                mem_im[pb_reg] <= r2fft_pkg::sat32(34'(ai_reg) - 34'(di_reg));
            end
            default:
            begin
            end
        endcase
        // Inverse bins are stored back scaled as they leave.
        if (scale_reg)
        begin
            mem_re[emit_idx_reg[AW-1:0]] <= ar_reg >>> shift_reg;
            mem_im[emit_idx_reg[AW-1:0]] <= ai_reg >>> shift_reg;
        end
        ar_reg <= mem_re[addr_a];
        ai_reg <= mem_im[addr_a];
        xr_reg <= mem_re[addr_b];
        xi_reg <= mem_im[addr_b];
        pa_reg <= addr_a;
        pb_reg <= addr_b;
        c_reg  <= cos_h;
        s_reg  <= cmd.inverse ? -sin_h : sin_h;
        shift_reg <= cmd.shift;
        emit_idx_reg  <= 6'(cmd.addr_a);
        emit_last_reg <= cmd.last;
        if (bf_mul_reg)
        begin
            dr_reg <= r2fft_pkg::sat32(dr_sat_in);
            di_reg <= r2fft_pkg::sat32(di_sat_in);
        end
    end

    // Read-to-multiply and read-to-emit stage flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bf_mul_reg <= 1'b0;
            emit_reg   <= 1'b0;
            scale_reg  <= 1'b0;
        end
        else
        begin
            bf_mul_reg <= (cmd.op == r2fft_pkg::OP_BF_RD);
            emit_reg   <= (cmd.op == r2fft_pkg::OP_EMIT);
            scale_reg  <= (cmd.op == r2fft_pkg::OP_SCALE);
        end
    end

    // Result registers; inverse scaling is an arithmetic shift at emit time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bin_valid <= 1'b0;
        else
            bin_valid <= emit_reg || scale_reg;
    end

    always_ff @(posedge clk)
    begin
        bin_real  <= ar_reg >>> shift_reg;
        bin_imag  <= ai_reg >>> shift_reg;
        bin_index <= emit_idx_reg;
        bin_last  <= emit_last_reg;
    end

endmodule

`default_nettype wire

// File: rtl/r2fft_ctrl.sv
// ----------------------------------------------------------------------------
// Radix-2 FFT controller
// Sequences loading, bit-reverse reorder, butterfly stages and bin output.
// ----------------------------------------------------------------------------
`default_nettype none

module r2fft_ctrl #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               frame_last,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [2:0]         cfg_data,
    output logic                    busy,
    output r2fft_pkg::dp_cmd_t      cmd
);

    // Largest length exponent whose length fits in the work memory.
    localparam int MAXL = $clog2(MAX_POINTS + 1) - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWAP_RD,
        S_SWAP_WR,
        S_BF_RD,
        S_BF_MUL,
        S_BF_WR,
        S_EMIT,
        S_DRAIN
    } state_t;

    state_t     state_reg;
    logic [2:0] size_reg;
    logic       inv_reg;
    logic [5:0] load_reg;
    logic [5:0] idx_reg;
    logic [2:0] stage_reg;
    logic [5:0] grp_reg;
    logic [5:0] j_reg;
    logic [1:0] drain_reg;

    // Effective length after clamping.
    logic [2:0] lg;
    logic [5:0] nmask;
    always_comb
    begin
        if (size_reg == 3'd0)
            lg = 3'd1;
        else if (size_reg > 3'(MAXL))
            lg = 3'(MAXL);
        else
            lg = size_reg;
        nmask = 6'((7'd1 << lg) - 7'd1);
    end

    // Bit reversal of idx_reg over lg bits.
    logic [5:0] rev;
    always_comb
    begin
        rev = '0;
        for (int b = 0; b < 6; b++)
            if (b < int'(lg))
                rev[int'(lg) - 1 - b] = idx_reg[b];
    end

    // Butterfly addresses: half = 2^stage, top = grp + j.
    logic [5:0] half;
    logic [5:0] top;
    assign half = 6'(7'd1 << stage_reg);
    assign top  = grp_reg | j_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.op       = r2fft_pkg::OP_NONE;
        cmd.inverse  = inv_reg;
        cmd.tw_step  = 5'((j_reg << (3'd5 - stage_reg)));
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.op     = (start) ? r2fft_pkg::OP_LOAD : r2fft_pkg::OP_NONE;
                cmd.addr_a = load_reg & nmask;
            end
            S_SWAP_RD:
            begin
                cmd.op     = r2fft_pkg::OP_SWAP_RD;
                cmd.addr_a = idx_reg;
                cmd.addr_b = rev;
            end
            S_SWAP_WR:
            begin
                cmd.op     = (idx_reg < rev) ? r2fft_pkg::OP_SWAP_WR : r2fft_pkg::OP_NONE;
                cmd.addr_a = idx_reg;
                cmd.addr_b = rev;
            end
            S_BF_RD:
            begin
                cmd.op     = r2fft_pkg::OP_BF_RD;
                cmd.addr_a = top;
                cmd.addr_b = top + half;
            end
            S_BF_MUL:
            begin
                // Keep the operand addresses so the read registers hold the pair.
                cmd.addr_a = top;
                cmd.addr_b = top + half;
            end
            S_BF_WR:
            begin
                cmd.op = r2fft_pkg::OP_BF_WR;
            end
            S_EMIT:
            begin
                cmd.op     = inv_reg ? r2fft_pkg::OP_SCALE : r2fft_pkg::OP_EMIT;
                cmd.addr_a = idx_reg;
                cmd.shift  = inv_reg ? lg : 3'd0;
                cmd.last   = (idx_reg == nmask);
            end
            default:
            begin
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // State, configuration and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            size_reg  <= 3'd6;
            inv_reg   <= 1'b0;
            load_reg  <= '0;
            idx_reg   <= '0;
            stage_reg <= '0;
            grp_reg   <= '0;
            j_reg     <= '0;
            drain_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == r2fft_pkg::REG_SIZE_LOG2)
                    size_reg <= cfg_data;
                else
                    inv_reg <= cfg_data[0];
            end
            unique case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        load_reg <= ((load_reg & nmask) + 6'd1) & nmask;
                        if (frame_last)
                        begin
                            load_reg  <= '0;
                            idx_reg   <= '0;
                            state_reg <= S_SWAP_RD;
                        end
                    end
                S_SWAP_RD:
                    state_reg <= S_SWAP_WR;
                S_SWAP_WR:
                    if (idx_reg == nmask)
                    begin
                        stage_reg <= '0;
                        grp_reg   <= '0;
                        j_reg     <= '0;
                        state_reg <= S_BF_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 6'd1;
                        state_reg <= S_SWAP_RD;
                    end
                S_BF_RD:
                    state_reg <= S_BF_MUL;
                S_BF_MUL:
                    state_reg <= S_BF_WR;
                S_BF_WR:
                begin
                    state_reg <= S_BF_RD;
                    if (j_reg + 6'd1 != half)
                        j_reg <= j_reg + 6'd1;
                    else
                    begin
                        j_reg <= '0;
                        if (((grp_reg + (half << 1)) & nmask) != 6'd0)
                            grp_reg <= grp_reg + (half << 1);
                        else
                        begin
                            grp_reg <= '0;
                            if (stage_reg + 3'd1 == lg)
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_EMIT;
                            end
                            else
                                stage_reg <= stage_reg + 3'd1;
                        end
                    end
                end
                S_EMIT:
                    if (idx_reg == nmask)
                    begin
                        drain_reg <= '0;
                        state_reg <= S_DRAIN;
                    end
                    else
                        idx_reg <= idx_reg + 6'd1;
                S_DRAIN:
                    if (drain_reg == 2'd1)
                        state_reg <= S_IDLE;
                    else
                        drain_reg <= drain_reg + 2'd1;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/radix2_complex_fft.sv
// ----------------------------------------------------------------------------
// Radix-2 complex FFT
// Fixed-point in-place decimation-in-time FFT of up to 64 points.
// ----------------------------------------------------------------------------
// Usage: write size_log2 (index 0) and inverse_mode (index 1) through cfg_we,
// cfg_index and cfg_data while the block is idle. Samples are transferred one
// per cycle when start is high and busy is low. The sample flagged with
// frame_last starts the transform: busy rises, the controller runs a
// bit-reversal pass over the N indexes, swapping each pair once, then
// log2(N) stages of N/2 butterflies, each read, multiplied and written
// through the single butterfly unit and its shared work memory. Bins then
// leave in natural order, one per cycle, each marked by bin_valid for
// exactly one cycle, with bin_last on the final one. The receiver cannot
// stall; results are transferred as they appear.
// Reset clears the controller and the load address; the work memory is
// undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module radix2_complex_fft #(
    parameter int MAX_POINTS   = 64,
    parameter int TWIDDLE_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [2:0]         cfg_data,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] sample_real,
    input  wire logic signed [15:0] sample_imag,
    input  wire logic               frame_last,
    output logic                    bin_valid,
    output logic signed [31:0]      bin_real,
    output logic signed [31:0]      bin_imag,
    output logic [5:0]              bin_index,
    output logic                    bin_last
);

    r2fft_pkg::dp_cmd_t cmd;

    r2fft_ctrl #(
        .MAX_POINTS(MAX_POINTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .frame_last(frame_last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .cmd       (cmd)
    );

    r2fft_datapath #(
        .MAX_POINTS  (MAX_POINTS),
        .TWIDDLE_BITS(TWIDDLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sample_real(sample_real),
        .sample_imag(sample_imag),
        .bin_valid  (bin_valid),
        .bin_real   (bin_real),
        .bin_imag   (bin_imag),
        .bin_index  (bin_index),
        .bin_last   (bin_last)
    );

    // A bin is only transferred while busy is high or has only just fallen.
    a_no_load_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid |-> busy || $past(busy))
        else $error("bin transferred while idle");

    // The last bin is always followed by no further bin.
    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid && bin_last |=> !bin_valid)
        else $error("bin after last bin");

    // Bin indexes count up by one within a frame.
    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid && !bin_last |=> !bin_valid || bin_index == $past(bin_index) + 6'd1)
        else $error("bin index out of order");

endmodule

`default_nettype wire
